@@ sv/base92_encoder_macros.svh @@
// assertion macros shared by the base92 encoder checkers
// expects clk and arst_n to be visible where a macro is used
`ifndef BASE92_ENCODER_MACROS_SVH
`define BASE92_ENCODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define B92_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define B92_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/b92_pkg.sv @@
// shared types, constants and helper functions of the base92 encoder
// no dependencies
`timescale 1ns / 1ps

package b92_pkg;

	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [4:0] GROUP_BITS = 5'd13;
	localparam logic [4:0] SHORT_BITS = 5'd6;
	localparam logic [7:0] RADIX      = 8'd91;
	// floor(v * 720 / 2^16) is v / 91 or one less for any 13-bit v
	localparam logic [9:0] QUO_RECIP  = 10'd720;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_CHAR,
		TAIL_PAIR
	} tail_kind_t;

	// one queued job: an optional full group and an optional flush tail
	typedef struct packed {
		logic        grp_vld;
		logic [12:0] grp_val;
		logic [6:0]  grp_quo;
		tail_kind_t  tail;
		logic [12:0] tail_val;   // short tail holds its index in the low six bits
		logic [6:0]  tail_quo;
		logic        fin;
	} b92_entry_t;

	// quotient estimate, may be one below the true value
	function automatic logic [6:0] quo_est(input logic [12:0] v);
		logic [22:0] p;
		p = 23'(v) * 23'(QUO_RECIP);
		return p[22:16];
	endfunction

	// alphabet: '!', then '#'..'_', then 'a'..'}'
	function automatic logic [6:0] alpha_code(input logic [6:0] idx);
		logic [6:0] code;
		if (idx == 7'd0) begin
			code = 7'd33;
		end else if (idx <= 7'd61) begin
			code = 7'(idx + 7'd34);
		end else begin
			code = 7'(idx + 7'd35);
		end
		return code;
	endfunction

endpackage

@@ sv/b92_fifo.sv @@
// short job queue between the front and back parts of the base92 encoder
// depends on b92_pkg for the entry type
`timescale 1ns / 1ps

module b92_fifo
	import b92_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  b92_entry_t wr_entry,
	input  logic       pop,
	output b92_entry_t rd_entry,
	output logic       full,
	output logic       empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b92_entry_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

@@ sv/b92_front.sv @@
// front part of the base92 encoder: bit accumulator, group split and flush tail
// depends on b92_pkg; feeds jobs into b92_fifo
`timescale 1ns / 1ps

module b92_front
	import b92_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,    // final_byte
	input  logic       q_full,
	output logic       push,
	output b92_entry_t entry
);

	logic [11:0] pend_q;
	logic [3:0]  cnt_q;

	logic        accept;
	logic [19:0] acc;
	logic [4:0]  cnt;
	logic        has_grp;
	logic [4:0]  rest;
	logic [19:0] grp_sh;
	logic [3:0]  cnt2;
	logic [19:0] mask;
	logic [19:0] acc2;
	logic [3:0]  sh_short;
	logic [3:0]  sh_pair;
	logic [5:0]  short_idx;
	logic [12:0] pair_val;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		acc      = {pend_q, s_tdata};
		cnt      = 5'({1'b0, cnt_q} + 5'd8);
		has_grp  = (cnt >= GROUP_BITS);
		rest     = 5'(cnt - GROUP_BITS);
		grp_sh   = acc >> rest[2:0];
		cnt2     = has_grp ? rest[3:0] : cnt[3:0];
		mask     = 20'((20'd1 << cnt2) - 20'd1);
		acc2     = acc & mask;
		sh_short = 4'(SHORT_BITS[3:0] - cnt2);
		sh_pair  = 4'(4'd13 - cnt2);
		short_idx = 6'(acc2[5:0] << sh_short[2:0]);
		pair_val  = 13'(acc2[12:0] << sh_pair[2:0]);

		entry.grp_vld  = has_grp;
		entry.grp_val  = grp_sh[12:0];
		entry.grp_quo  = quo_est(grp_sh[12:0]);
		entry.fin      = s_tlast;
		entry.tail_val = pair_val;
		entry.tail_quo = quo_est(pair_val);
		if (!s_tlast || cnt2 == 4'd0) begin
			entry.tail = TAIL_NONE;
		end else if ({1'b0, cnt2} <= SHORT_BITS) begin
			entry.tail     = TAIL_CHAR;
			entry.tail_val = {7'd0, short_idx};
		end else begin
			entry.tail = TAIL_PAIR;
		end
	end

	// a byte that only fills the accumulator queues nothing
	assign push = accept && (has_grp || s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= acc2[11:0];
				cnt_q  <= cnt2;
			end
		end
	end

endmodule

@@ sv/b92_back.sv @@
// back part of the base92 encoder: walks each job one character per cycle while the receiver is ready
// depends on b92_pkg; drains b92_fifo into the output register
`timescale 1ns / 1ps

module b92_back
	import b92_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  b92_entry_t entry,
	input  logic       q_empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [6:0] char_code, [7] zero
	output logic       m_tlast     // final_char
);

	logic [1:0] ptr_q;
	logic       vld_q;
	logic [6:0] code_q;
	logic       last_q;

	logic        load;
	logic        emit;
	logic [2:0]  n_chars;
	logic [2:0]  tail_chars;
	logic        in_grp;
	logic [1:0]  tpos;
	logic        hi;
	logic        direct;
	logic [12:0] sel_val;
	logic [6:0]  sel_quo;
	logic [12:0] prod;
	logic [12:0] diff;
	logic [7:0]  rem0;
	logic [6:0]  quo;
	logic [6:0]  rem;
	logic [6:0]  idx;
	logic        is_last;

	always_comb begin
		unique case (entry.tail)
			TAIL_NONE: tail_chars = 3'd0;
			TAIL_CHAR: tail_chars = 3'd1;
			TAIL_PAIR: tail_chars = 3'd2;
			default:   tail_chars = 3'd0;
		endcase
		n_chars = 3'(tail_chars + (entry.grp_vld ? 3'd2 : 3'd0));
		in_grp  = entry.grp_vld && !ptr_q[1];
		tpos    = entry.grp_vld ? 2'(ptr_q - 2'd2) : ptr_q;
		direct  = !in_grp && (entry.tail == TAIL_CHAR);
		hi      = in_grp ? !ptr_q[0] : !tpos[0];
		sel_val = in_grp ? entry.grp_val : entry.tail_val;
		sel_quo = in_grp ? entry.grp_quo : entry.tail_quo;

		// remainder from the quotient estimate, then one correction step
		prod = 13'(sel_quo) * 13'(RADIX);
		diff = 13'(sel_val - prod);
		rem0 = diff[7:0];
		if (rem0 >= RADIX) begin
			quo = 7'(sel_quo + 7'd1);
			rem = 7'(rem0 - RADIX);
		end else begin
			quo = sel_quo;
			rem = rem0[6:0];
		end

		if (direct) begin
			idx = {1'b0, entry.tail_val[5:0]};
		end else begin
			idx = hi ? quo : rem;
		end
		is_last = ({1'b0, ptr_q} == 3'(n_chars - 3'd1));
	end

	assign load = !vld_q || m_tready;
	assign emit = load && !q_empty;
	assign pop  = emit && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			vld_q  <= 1'b0;
			code_q <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			vld_q <= emit;
			if (emit) begin
				code_q <= alpha_code(idx);
				last_q <= is_last && entry.fin;
				ptr_q  <= is_last ? 2'd0 : 2'(ptr_q + 2'd1);
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {1'b0, code_q};
	assign m_tlast  = last_q;

endmodule

@@ sv/base92_encoder.sv @@
// base92 encoder top level: front accumulator, job queue and character sequencer
// depends on b92_pkg, b92_front, b92_fifo and b92_back
//
// usage:
//   input stream s_*: one byte per transaction in s_tdata[7:0], bits used msb
//   first; s_tlast marks the last byte of a message and flushes leftover bits.
//   output stream m_*: one character per transaction, ascii code in
//   m_tdata[6:0]; m_tlast marks the last character of the message.
// every 13 accumulated bits give two characters; a flush of 1 to 6 bits gives
// one more, of 7 to 12 bits two more, so a byte yields 0 to 4 characters.
// the first character of a byte passes through the job queue and then the
// output register. throughput: one byte per cycle in while the job queue has room,
// one character per cycle out while the receiver is ready; the output
// sequencer sets the sustained rate.
// a stalled receiver holds the output register; the queue keeps taking bytes
// until it is full, then s_tready drops.
// reset clears the accumulator, the queue and the output register.
`timescale 1ns / 1ps

module base92_encoder
	import b92_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,    // final_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [6:0] char_code, [7] zero
	output logic       m_tlast     // final_char
);

	b92_entry_t wr_entry;
	b92_entry_t rd_entry;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	b92_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	b92_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	b92_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (rd_entry),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sv/b92_checker.sv @@
// port-level checks for the base92 encoder, bound to the top level
// depends on base92_encoder_macros.svh
`timescale 1ns / 1ps
`include "base92_encoder_macros.svh"

module b92_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// a stalled output transaction keeps its payload
	`B92_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	// only alphabet characters leave the block
	`B92_ASSERT_NOW(a_char_range, m_tvalid, m_tdata[7] == 1'b0 && m_tdata[6:0] >= 7'd33 && m_tdata[6:0] <= 7'd125 && m_tdata[6:0] != 7'd34 && m_tdata[6:0] != 7'd96, "character outside alphabet")

	// with the output register empty the queue cannot be full
	`B92_ASSERT_NOW(a_ready_when_idle, !m_tvalid, s_tready, "input stalled while output idle")

endmodule

bind base92_encoder b92_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ sim/base92_encoder_test.sv @@
// self-checking testbench for the base92 encoder: table-driven and random byte streams
// depends on base92_encoder; characters are checked against a behavioral encoder or typed table rows
`timescale 1ns / 1ps

module base92_encoder_test;

	localparam int unsigned GROUP_LEN   = 13;
	localparam int unsigned SHORT_LEN   = 6;
	localparam int unsigned RADIX_N     = 91;
	localparam int unsigned CH_BANG     = 33;   // '!'
	localparam int unsigned CH_HASH     = 35;   // '#'
	localparam int unsigned CH_LOWER_A  = 97;   // 'a'
	localparam int          RANDOM_BYTES = 300;
	localparam int          CALM_AFTER   = 250;  // random bytes sent before idling stops
	localparam int          QUIET_LIMIT  = 500;
	localparam int          N_DIR        = 26;

	typedef struct packed {
		logic [6:0] code;
		logic       fin;
	} enc_char_t;

	// want holds the typed characters, used only when typed is set
	typedef struct packed {
		logic [7:0]      data;
		logic            fin;
		logic            typed;
		logic [2:0]      n_want;
		logic [0:3][6:0] want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// table row travelling alongside the byte in flight
	logic            row_typed;
	logic [2:0]      row_n_want;
	logic [0:3][6:0] row_want;

	logic [11:0] pend_bits;
	logic [3:0]  pend_cnt;
	enc_char_t   chars_due[$];

	logic        tx_gaps_on;
	logic        rx_stalls_on;
	int          stall_left;
	int          quiet_cycles;
	int          err_count;
	int          bytes_sent;
	int          msgs_sent;
	int          chars_checked;
	logic [12:0] tails_seen;

	dir_row_t dir_rows [N_DIR] = '{
		// single bytes after reset, flushed as a zero-padded pair
		'{8'h00, 1'b1, 1'b1, 3'd2, {7'd33, 7'd33, 7'd0, 7'd0}},
		'{8'hFF, 1'b1, 1'b1, 3'd2, {7'd124, 7'd95, 7'd0, 7'd0}},
		// two bytes: group plus a short tail
		'{8'h80, 1'b0, 1'b0, 3'd0, '0},
		'{8'h01, 1'b1, 1'b0, 3'd0, '0},
		// thirteen 0xFF bytes: all-ones groups, ends with nothing left over
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b1, 1'b0, 3'd0, '0},
		// nine bytes: last one gives a group and a two-character tail
		'{8'hA5, 1'b0, 1'b0, 3'd0, '0},
		'{8'h5A, 1'b0, 1'b0, 3'd0, '0},
		'{8'hA5, 1'b0, 1'b0, 3'd0, '0},
		'{8'h5A, 1'b0, 1'b0, 3'd0, '0},
		'{8'h00, 1'b0, 1'b0, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, '0},
		'{8'h01, 1'b0, 1'b0, 3'd0, '0},
		'{8'h80, 1'b0, 1'b0, 3'd0, '0},
		'{8'h7F, 1'b1, 1'b0, 3'd0, '0}
	};

	base92_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [6:0] ascii_of(input int unsigned idx);
		if (idx == 0) begin
			return 7'(CH_BANG);
		end else if (idx <= 61) begin
			return 7'(CH_HASH + idx - 1);
		end else begin
			return 7'(CH_LOWER_A + idx - 62);
		end
	endfunction

	// advances the bit accumulator by one byte and returns the characters it yields
	task automatic encode_byte(input logic [7:0] b, input logic fin, output int n,
			output enc_char_t [0:3] made);
		int unsigned acc;
		int unsigned cnt;
		int unsigned rest;
		int unsigned v;
		n = 0;
		made = '0;
		acc = (int'(pend_bits) << 8) | int'(b);
		cnt = int'(pend_cnt) + 8;
		if (cnt >= GROUP_LEN) begin
			rest = cnt - GROUP_LEN;
			v = (acc >> rest) & 'h1FFF;
			made[n] = '{ascii_of(v / RADIX_N), 1'b0};
			made[n + 1] = '{ascii_of(v % RADIX_N), 1'b0};
			n += 2;
			acc &= (1 << rest) - 1;
			cnt = rest;
		end
		if (fin) begin
			tails_seen[cnt] = 1'b1;
			if (cnt >= 1 && cnt <= SHORT_LEN) begin
				made[n] = '{ascii_of((acc << (SHORT_LEN - cnt)) & 'h3F), 1'b0};
				n += 1;
			end else if (cnt > SHORT_LEN) begin
				v = acc << (GROUP_LEN - cnt);
				made[n] = '{ascii_of(v / RADIX_N), 1'b0};
				made[n + 1] = '{ascii_of(v % RADIX_N), 1'b0};
				n += 2;
			end
			if (n > 0)
				made[n - 1].fin = 1'b1;
			pend_bits = '0;
			pend_cnt = '0;
		end else begin
			pend_bits = 12'(acc);
			pend_cnt = 4'(cnt);
		end
	endtask

	task automatic flag_error(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		err_count++;
	endtask

	// character check first, then the byte transaction of the same edge
	always @(posedge clk) begin : scoreboard
		enc_char_t       due;
		enc_char_t [0:3] made;
		int              n;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				chars_checked++;
				if (chars_due.size() == 0) begin
					flag_error($sformatf("character 0x%02h with nothing expected", m_tdata));
				end else begin
					due = chars_due.pop_front();
					if (m_tdata[6:0] !== due.code)
						flag_error($sformatf("char_code %0d, expected %0d",
							m_tdata[6:0], due.code));
					if (m_tdata[7] !== 1'b0)
						flag_error("padding bit of m_tdata set");
					if (m_tlast !== due.fin)
						flag_error($sformatf("final_char %b, expected %b", m_tlast, due.fin));
				end
			end
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata, s_tlast, n, made);
				if (s_tlast)
					msgs_sent++;
				if (row_typed) begin
					for (int i = 0; i < row_n_want; i++)
						chars_due.insert(chars_due.size(),
							enc_char_t'{row_want[i], s_tlast && (i == row_n_want - 1)});
				end else begin
					for (int i = 0; i < n; i++)
						chars_due.insert(chars_due.size(), made[i]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input logic [2:0] n_want, input logic [0:3][6:0] want);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		row_typed <= typed;
		row_n_want <= n_want;
		row_want <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// hold the input until every pending character has come out
	task automatic drain_output;
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (chars_due.size() != 0);
	endtask

	initial begin
		int  len;
		int  random_sent;
		bit  drained_mid;
		logic [7:0] b;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		row_typed = 1'b0;
		row_n_want = '0;
		row_want = '0;
		pend_bits = '0;
		pend_cnt = '0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		stall_left = 0;
		quiet_cycles = 0;
		err_count = 0;
		bytes_sent = 0;
		msgs_sent = 0;
		chars_checked = 0;
		tails_seen = '0;
		random_sent = 0;
		drained_mid = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i].n_want, dir_rows[i].want);
		drain_output();

		while (random_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 3) == 0)
				len = $urandom_range(10, 30);
			else
				len = $urandom_range(1, 9);
			tx_gaps_on = (random_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			rx_stalls_on = (random_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			if (!drained_mid && random_sent >= RANDOM_BYTES / 2) begin
				drain_output();
				drained_mid = 1;
			end
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 9))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, k == len - 1, 1'b0, 3'd0, '0);
				random_sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (chars_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d bytes in %0d messages, checked %0d characters",
			bytes_sent, msgs_sent, chars_checked);
		$display("leftover bit counts flushed at message end (bit n = n bits): %b", tails_seen);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
